// File: rtl/core/timed_event_queue_top_macros.svh
// Assertion macros shared by the timed event queue RTL.
`ifndef TIMED_EVENT_QUEUE_TOP_MACROS_SVH
`define TIMED_EVENT_QUEUE_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition leads to a consequence on the same clock edge.
`define TEQ_ASSERT_IMP(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tev_pkg.sv
// Shared types, constants and helpers of the timed event queue.
`timescale 1ns / 1ps
`default_nettype none

package tev_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] KIND_POS  = 2'd0;
    localparam logic [1:0] KIND_FLAT = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_VOL  = 2'd3;

    localparam logic [2:0] RT_ENQ   = 3'd0;
    localparam logic [2:0] RT_FULL  = 3'd1;
    localparam logic [2:0] RT_DISP  = 3'd2;
    localparam logic [2:0] RT_TICK  = 3'd3;
    localparam logic [2:0] RT_CLEAR = 3'd4;

    localparam logic [31:0] PERIOD_RESET = 32'd655360;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] sound;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] level;
        logic [3:0]  category;
        logic [31:0] due;
        logic        done;
    } t_entry;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/timed_event_queue_top.sv
// Timed event queue: a chain of cells holding delayed commands, with a sequencing controller.
//
// Usage: an item arrives on the input channel (valid/ready) with a command. An enqueue
// gives one result, a clear gives one result, a tick gives one result per dispatched
// entry followed by a tick-done result; command 3 gives none. The last flag marks the
// final result of an item. The user must write the compaction period on the configuration
// channel only while the block is idle; the block does not enforce this. The channel is always ready.
// An enqueue or a clear is accepted into its command state, from which the result
// register takes its result. A tick with F stored entries walks the cell chain up to
// three times: a counting pass, a dispatch pass that also waits out any output stall,
// and, when time exceeds the compaction period, a compaction pass, then the tick-done
// result. The chain moves one cell per cycle, except while a dispatch waits on an output
// stall. One item is worked on at a time.
// Reset clears the fill count, time, pending count and the output valid; the period
// returns to 10.0 s. Cells need no clearing. When the receiver holds ready low, the
// result register keeps its item and the controller waits before the next result.
`timescale 1ns / 1ps
`default_nettype none

module timed_event_queue_top
    import tev_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [1:0]  i_event_kind,
    input  wire logic [31:0] i_sound_id,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [31:0] i_level,
    input  wire logic [3:0]  i_category,
    input  wire logic [31:0] i_delay,
    input  wire logic [31:0] i_elapsed,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_result_type,
    output logic [5:0]       o_slot,
    output logic [1:0]       o_out_kind,
    output logic [31:0]      o_out_sound,
    output logic [31:0]      o_out_pos_x,
    output logic [31:0]      o_out_pos_y,
    output logic [31:0]      o_out_pos_z,
    output logic [31:0]      o_out_level,
    output logic [3:0]       o_out_category,
    output logic [5:0]       o_pending,
    output logic             o_last
);

`include "timed_event_queue_top_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ENQ   = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_CNT   = 3'd3;
    localparam logic [2:0] ST_DISP  = 3'd4;
    localparam logic [2:0] ST_COMP  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]       r_state;
    logic [31:0]      r_period;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_pending;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_len;
    logic [IDX_W-1:0] r_i;
    t_entry           r_item;

    logic             r_ovalid;
    logic [2:0]       r_rtype;
    logic [5:0]       r_slot;
    t_entry           r_oent;
    logic [5:0]       r_opend;
    logic             r_olast;

    logic             w_shift;
    logic             w_load;
    logic [IDX_W-1:0] w_load_idx;
    t_entry           w_wdata;
    t_entry           w_head;
    t_entry           w_enq;
    logic             w_elig;
    logic             w_out_free;
    logic             w_pass_end;
    logic [CNT_W-1:0] w_cnt_final;

    tev_chain u_chain (
        .i_clk      (i_clk),
        .i_shift    (w_shift),
        .i_load     (w_load),
        .i_load_idx (w_load_idx),
        .i_wdata    (w_wdata),
        .o_head     (w_head)
    );

    assign w_out_free  = !r_ovalid || i_out_ready;
    assign w_elig      = !w_head.done && (w_head.due <= r_now);
    assign w_pass_end  = (r_i == IDX_W'(r_fill - CNT_W'(1)));
    assign w_cnt_final = r_cnt + CNT_W'(w_elig);

    // Unused words of a kind are stored as zero.
    always_comb begin
        w_enq          = r_item;
        w_enq.sound    = (r_item.kind == KIND_VOL) ? 32'd0 : r_item.sound;
        w_enq.pos_x    = (r_item.kind == KIND_POS) ? r_item.pos_x : 32'd0;
        w_enq.pos_y    = (r_item.kind == KIND_POS) ? r_item.pos_y : 32'd0;
        w_enq.pos_z    = (r_item.kind == KIND_POS) ? r_item.pos_z : 32'd0;
        w_enq.level    = (r_item.kind == KIND_STOP) ? 32'd0 : r_item.level;
        w_enq.category = (r_item.kind == KIND_STOP) ? 4'd0 : r_item.category;
        w_enq.due      = sat_add(r_now, r_item.due);
        w_enq.done     = 1'b0;
    end

    // Chain control: a pass pops the head and writes it back at the end of the live region.
    always_comb begin
        w_shift    = 1'b0;
        w_load     = 1'b0;
        w_load_idx = IDX_W'(r_fill - CNT_W'(1));
        w_wdata    = w_head;
        unique case (r_state)
            ST_ENQ: begin
                w_load     = w_out_free && (r_fill < CNT_W'(QUEUE_DEPTH));
                w_load_idx = IDX_W'(r_fill);
                w_wdata    = w_enq;
            end
            ST_CNT: begin
                w_shift = 1'b1;
                w_load  = 1'b1;
            end
            ST_DISP: begin
                w_shift      = !w_elig || w_out_free;
                w_load       = w_shift;
                w_wdata.done = w_head.done || w_elig;
            end
            ST_COMP: begin
                w_shift     = 1'b1;
                w_load      = !w_head.done;
                w_load_idx  = IDX_W'(r_len - CNT_W'(1));
                w_wdata.due = (w_head.due > r_now) ? (w_head.due - r_now) : 32'd0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_period  <= PERIOD_RESET;
            r_now     <= 32'd0;
            r_fill    <= '0;
            r_pending <= '0;
            r_cnt     <= '0;
            r_len     <= '0;
            r_i       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt <= '0;
                        r_i   <= '0;
                        unique case (i_command)
                            CMD_ENQ:   r_state <= ST_ENQ;
                            CMD_CLEAR: r_state <= ST_CLEAR;
                            CMD_TICK: begin
                                r_now   <= sat_add(r_now, i_elapsed);
                                r_state <= (r_fill != '0) ? ST_CNT : ST_DONE;
                            end
                            default:   r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_ENQ: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= 1'b1;
                        r_oent   <= '0;
                        if (r_fill < CNT_W'(QUEUE_DEPTH)) begin
                            r_rtype   <= RT_ENQ;
                            r_slot    <= 6'(r_fill);
                            r_fill    <= r_fill + CNT_W'(1);
                            r_pending <= r_pending + CNT_W'(1);
                            r_opend   <= 6'(r_pending + CNT_W'(1));
                        end else begin
                            r_rtype <= RT_FULL;
                            r_slot  <= '0;
                            r_opend <= 6'(r_pending);
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_CLEAR: begin
                    if (w_out_free) begin
                        r_fill    <= '0;
                        r_now     <= 32'd0;
                        r_pending <= '0;
                        r_ovalid  <= 1'b1;
                        r_rtype   <= RT_CLEAR;
                        r_slot    <= '0;
                        r_oent    <= '0;
                        r_opend   <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_CNT: begin
                    r_cnt <= w_cnt_final;
                    r_i   <= r_i + IDX_W'(1);
                    if (w_pass_end) begin
                        r_pending <= r_pending - w_cnt_final;
                        r_i       <= '0;
                        r_state   <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    if (w_shift) begin
                        if (w_elig) begin
                            r_ovalid      <= 1'b1;
                            r_rtype       <= RT_DISP;
                            r_slot        <= '0;
                            r_oent        <= w_head;
                            r_opend       <= 6'(r_pending);
                            r_olast       <= 1'b0;
                        end
                        r_i <= r_i + IDX_W'(1);
                        if (w_pass_end) begin
                            r_i     <= '0;
                            r_len   <= r_fill;
                            r_state <= (r_now > r_period) ? ST_COMP : ST_DONE;
                        end
                    end
                end
                ST_COMP: begin
                    if (w_head.done) begin
                        r_len <= r_len - CNT_W'(1);
                    end
                    r_i <= r_i + IDX_W'(1);
                    if (w_pass_end) begin
                        r_fill  <= w_head.done ? (r_len - CNT_W'(1)) : r_len;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_now > r_period) begin
                            r_now <= 32'd0;
                        end
                        r_ovalid <= 1'b1;
                        r_rtype  <= RT_TICK;
                        r_slot   <= '0;
                        r_oent   <= '0;
                        r_opend  <= 6'(r_pending);
                        r_olast  <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Input item is captured on acceptance; the delay travels in the due field.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item.kind     <= i_event_kind;
            r_item.sound    <= i_sound_id;
            r_item.pos_x    <= i_pos_x;
            r_item.pos_y    <= i_pos_y;
            r_item.pos_z    <= i_pos_z;
            r_item.level    <= i_level;
            r_item.category <= i_category;
            r_item.due      <= i_delay;
            r_item.done     <= 1'b0;
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ovalid;
    assign o_result_type  = r_rtype;
    assign o_slot         = r_slot;
    assign o_out_kind     = r_oent.kind;
    assign o_out_sound    = r_oent.sound;
    assign o_out_pos_x    = r_oent.pos_x;
    assign o_out_pos_y    = r_oent.pos_y;
    assign o_out_pos_z    = r_oent.pos_z;
    assign o_out_level    = r_oent.level;
    assign o_out_category = r_oent.category;
    assign o_pending      = r_opend;
    assign o_last         = r_olast;

    `TEQ_ASSERT(a_fill_bound, r_fill <= CNT_W'(QUEUE_DEPTH), "fill count beyond queue depth")
    `TEQ_ASSERT(a_pend_bound, r_pending <= r_fill, "pending count exceeds fill count")
    `TEQ_ASSERT_IMP(a_disp_not_last, r_ovalid && (r_rtype == RT_DISP), !r_olast, "dispatch marked last")
    `TEQ_ASSERT_IMP(a_comp_len, r_state == ST_COMP, r_len <= r_fill, "compaction length overran")

endmodule

`default_nettype wire

// File: rtl/core/tev_cell.sv
// One storage cell of the queue chain: loads a new entry or takes its right neighbour's.
`timescale 1ns / 1ps
`default_nettype none

module tev_cell
    import tev_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_shift,
    input  wire logic   i_load,
    input  wire t_entry i_next,
    input  wire t_entry i_wdata,
    output t_entry      o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_wdata;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: rtl/core/tev_chain.sv
// Row of queue cells; slot order runs from the head cell towards the tail.
`timescale 1ns / 1ps
`default_nettype none

module tev_chain
    import tev_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire logic             i_load,
    input  wire logic [IDX_W-1:0] i_load_idx,
    input  wire t_entry           i_wdata,
    output t_entry                o_head
);

    t_entry w_cell [QUEUE_DEPTH];

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_entry w_next;
        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_next = i_wdata;
        end else begin : g_mid
            assign w_next = w_cell[k+1];
        end
        tev_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_load  (i_load && (i_load_idx == IDX_W'(k))),
            .i_next  (w_next),
            .i_wdata (i_wdata),
            .o_entry (w_cell[k])
        );
    end

    assign o_head = w_cell[0];

endmodule

`default_nettype wire

// File: tb/sv/tb_timed_event_queue_top.sv
// Self-checking testbench for the timed event queue, with its own model of the queue.
`timescale 1ns / 1ps

module tb_timed_event_queue_top;
    import tev_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int IDLE_WAIT = 120;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  kind;
        logic [31:0] sound;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] level;
        logic [3:0]  category;
        logic [31:0] delay;
        logic [31:0] elapsed;
    } t_request;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [5:0]  slot;
        logic [1:0]  kind;
        logic [31:0] sound;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] level;
        logic [3:0]  category;
        logic [5:0]  pending;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_command;
    logic [1:0]  i_event_kind;
    logic [31:0] i_sound_id;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic [31:0] i_level;
    logic [3:0]  i_category;
    logic [31:0] i_delay;
    logic [31:0] i_elapsed;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_result_type;
    logic [5:0]  o_slot;
    logic [1:0]  o_out_kind;
    logic [31:0] o_out_sound;
    logic [31:0] o_out_pos_x;
    logic [31:0] o_out_pos_y;
    logic [31:0] o_out_pos_z;
    logic [31:0] o_out_level;
    logic [3:0]  o_out_category;
    logic [5:0]  o_pending;
    logic        o_last;

    timed_event_queue_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_event_kind(i_event_kind), .i_sound_id(i_sound_id),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z), .i_level(i_level),
        .i_category(i_category), .i_delay(i_delay), .i_elapsed(i_elapsed),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_type(o_result_type), .o_slot(o_slot), .o_out_kind(o_out_kind),
        .o_out_sound(o_out_sound), .o_out_pos_x(o_out_pos_x), .o_out_pos_y(o_out_pos_y),
        .o_out_pos_z(o_out_pos_z), .o_out_level(o_out_level),
        .o_out_category(o_out_category), .o_pending(o_pending), .o_last(o_last)
    );

    // Model state of the queue.
    t_entry      table_q [QUEUE_DEPTH];
    int          fill_cnt;
    logic [31:0] now_t;
    logic [31:0] period;

    t_result expected_results[$];
    int      mismatch_cnt;
    bit      orphan_seen;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [5:0] count_pending();
        int n;
        n = 0;
        for (int i = 0; i < fill_cnt; i++)
            if (!table_q[i].done) n++;
        return n[5:0];
    endfunction

    // Works out the results of one accepted item and queues them.
    function automatic void predict_queue_step(t_request rq);
        t_result res;
        t_result tick_res[$];
        t_entry  e;
        int      w;
        logic [5:0] pend;
        res = '0;
        res.last = 1'b1;
        case (rq.command)
            CMD_ENQ: begin
                if (fill_cnt >= QUEUE_DEPTH) begin
                    res.rtype = RT_FULL;
                end else begin
                    e = '0;
                    e.kind = rq.kind;
                    e.sound = (rq.kind == KIND_VOL) ? '0 : rq.sound;
                    if (rq.kind == KIND_POS) begin
                        e.pos_x = rq.pos_x;
                        e.pos_y = rq.pos_y;
                        e.pos_z = rq.pos_z;
                    end
                    e.level = (rq.kind == KIND_STOP) ? '0 : rq.level;
                    e.category = (rq.kind == KIND_STOP) ? '0 : rq.category;
                    e.due = add_sat(now_t, rq.delay);
                    table_q[fill_cnt] = e;
                    res.rtype = RT_ENQ;
                    res.slot = fill_cnt[5:0];
                    fill_cnt++;
                end
                res.pending = count_pending();
                expected_results.push_back(res);
            end
            CMD_CLEAR: begin
                fill_cnt = 0;
                now_t = '0;
                res.rtype = RT_CLEAR;
                expected_results.push_back(res);
            end
            CMD_TICK: begin
                now_t = add_sat(now_t, rq.elapsed);
                for (int i = 0; i < fill_cnt; i++) begin
                    if (!table_q[i].done && table_q[i].due <= now_t) begin
                        res = '0;
                        res.rtype = RT_DISP;
                        res.kind = table_q[i].kind;
                        res.sound = table_q[i].sound;
                        res.pos_x = table_q[i].pos_x;
                        res.pos_y = table_q[i].pos_y;
                        res.pos_z = table_q[i].pos_z;
                        res.level = table_q[i].level;
                        res.category = table_q[i].category;
                        table_q[i].done = 1'b1;
                        tick_res.push_back(res);
                    end
                end
                if (now_t > period) begin
                    w = 0;
                    for (int i = 0; i < fill_cnt; i++) begin
                        if (!table_q[i].done) begin
                            e = table_q[i];
                            e.due = (e.due > now_t) ? e.due - now_t : '0;
                            table_q[w] = e;
                            w++;
                        end
                    end
                    fill_cnt = w;
                    now_t = '0;
                end
                res = '0;
                res.rtype = RT_TICK;
                res.last = 1'b1;
                tick_res.push_back(res);
                pend = count_pending();
                foreach (tick_res[k]) begin
                    tick_res[k].pending = pend;
                    expected_results.push_back(tick_res[k]);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] random_time(logic [31:0] span);
        if ($urandom_range(0, 19) == 0) return $urandom;
        return $urandom_range(0, span);
    endfunction

    function automatic t_request random_request(logic [1:0] cmd, logic [31:0] span);
        t_request rq;
        rq.command = cmd;
        rq.kind = $urandom_range(0, 3);
        rq.sound = $urandom;
        rq.pos_x = $urandom;
        rq.pos_y = $urandom;
        rq.pos_z = $urandom;
        rq.level = $urandom;
        rq.category = $urandom_range(0, 15);
        rq.delay = random_time(span);
        rq.elapsed = random_time(span);
        return rq;
    endfunction

    // Sends one item; valid is only lowered when a gap is taken.
    task automatic send_item(t_request rq, bit with_gap);
        int gap;
        gap = with_gap ? random_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= rq.command;
        i_event_kind <= rq.kind;
        i_sound_id <= rq.sound;
        i_pos_x <= rq.pos_x;
        i_pos_y <= rq.pos_y;
        i_pos_z <= rq.pos_z;
        i_level <= rq.level;
        i_category <= rq.category;
        i_delay <= rq.delay;
        i_elapsed <= rq.elapsed;
        do @(posedge i_clk); while (!o_in_ready);
        predict_queue_step(rq);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_period(logic [31:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        period = value;
    endtask

    // Extremes of every field, each kind, saturation, the unknown command and clear.
    task automatic test_directed();
        t_request rq;
        rq = '1;
        for (int k = 0; k < 4; k++) begin
            rq.command = CMD_ENQ;
            rq.kind = k[1:0];
            rq.delay = (k == 3) ? 32'hFFFF_FFFF : '0;
            send_item(rq, 1'b1);
        end
        rq = '0;
        for (int k = 0; k < 4; k++) begin
            rq.kind = k[1:0];
            rq.delay = 32'h0001_0000;
            send_item(rq, 1'b0);
        end
        rq = '0;
        rq.command = CMD_TICK;
        send_item(rq, 1'b1);
        rq.elapsed = 32'h0001_0000;
        send_item(rq, 1'b1);
        rq.command = CMD_NOP;
        send_item(rq, 1'b1);
        rq.command = CMD_TICK;
        rq.elapsed = 32'hFFFF_FFFF;
        send_item(rq, 1'b0);
        rq = random_request(CMD_ENQ, 32'h0002_0000);
        send_item(rq, 1'b1);
        rq.command = CMD_CLEAR;
        send_item(rq, 1'b1);
        rq = random_request(CMD_TICK, 32'h0002_0000);
        send_item(rq, 1'b1);
    endtask

    // Fills the table past its depth, then drains it with one long tick.
    task automatic test_full_table();
        t_request rq;
        for (int k = 0; k < QUEUE_DEPTH + 2; k++)
            send_item(random_request(CMD_ENQ, 32'h0004_0000), 1'b1);
        rq = random_request(CMD_TICK, 0);
        rq.elapsed = 32'hFFFF_FFFF;
        send_item(rq, 1'b1);
    endtask

    // Mostly enqueue and tick sequences, with a little clearing and noise.
    task automatic test_random_traffic(int n_items, logic [31:0] span);
        int r;
        logic [1:0] cmd;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 58) cmd = CMD_ENQ;
            else if (r < 94) cmd = CMD_TICK;
            else if (r < 97) cmd = CMD_CLEAR;
            else cmd = CMD_NOP;
            send_item(random_request(cmd, span), 1'b1);
        end
    endtask

    // Receiver side: random stalls, mostly short.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                stall = random_gap();
                i_out_ready <= (stall == 0);
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    initial begin
        t_result got;
        t_result want;
        mismatch_cnt = 0;
        orphan_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = {o_result_type, o_slot, o_out_kind, o_out_sound, o_out_pos_x,
                       o_out_pos_y, o_out_pos_z, o_out_level, o_out_category,
                       o_pending, o_last};
                if (expected_results.size() == 0) begin
                    orphan_seen = 1'b1;
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result item: %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $write("mismatch (expected/actual): type %0d/%0d slot %0d/%0d",
                                   want.rtype, got.rtype, want.slot, got.slot);
                            $write(" kind %0d/%0d sound %h/%h x %h/%h y %h/%h",
                                   want.kind, got.kind, want.sound, got.sound,
                                   want.pos_x, got.pos_x, want.pos_y, got.pos_y);
                            $display(" z %h/%h level %h/%h cat %0d/%0d pend %0d/%0d last %0d/%0d",
                                     want.pos_z, got.pos_z, want.level, got.level,
                                     want.category, got.category,
                                     want.pending, got.pending, want.last, got.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_command = '0;
        i_event_kind = '0;
        i_sound_id = '0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_level = '0;
        i_category = '0;
        i_delay = '0;
        i_elapsed = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        fill_cnt = 0;
        now_t = '0;
        period = PERIOD_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_random_traffic(80, 32'h0003_0000);
        write_period(32'd1);
        test_random_traffic(60, 32'h0000_0004);
        write_period(32'hFFFF_FFFF);
        test_full_table();
        test_random_traffic(60, 32'h0004_0000);
        write_period(32'h0002_8000);
        test_random_traffic(35, 32'h0001_0000);
        write_period(PERIOD_RESET);
        test_random_traffic(40, 32'h0003_0000);

        wait_idle();
        if (mismatch_cnt == 0 && !orphan_seen && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/tev_pkg.sv
rtl/core/tev_cell.sv
rtl/core/tev_chain.sv
rtl/core/timed_event_queue_top.sv
tb/sv/tb_timed_event_queue_top.sv
